// ----- src/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator: operator
// and error codes, character codes, parser phases and the command format.
// ----------------------------------------------------------------------------
package iee_pkg;

	// arithmetic width of operands and results
	localparam int VW = 32;
	// width of the divider step counter
	localparam int DIV_CW = $clog2(VW + 1);

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_DIV0    = 2'd1,
		ERR_MISSING = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		PH_WAIT_NUM,
		PH_IN_NUM,
		PH_WAIT_OP
	} phase_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DIV
	} bstate_t;

	// one classified request from the parser to the evaluator
	typedef struct packed {
		logic          has_num;
		logic [VW-1:0] num;
		logic          has_op;
		op_t           op;
		logic          is_end;
	} cmd_t;

endpackage

// ----- src/iee_front.sv -----
// ----------------------------------------------------------------------------
// iee_front
// Character parser: accumulates decimal numbers, recognizes operators and
// turns each character into at most one request for the evaluator.
// ----------------------------------------------------------------------------
module iee_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    char_code,
	input  logic          last,
	input  logic          q_full,
	output logic          cmd_valid,
	output iee_pkg::cmd_t cmd
);
	import iee_pkg::*;

	phase_t        phase_q, phase_d;
	logic [VW-1:0] acc_q, acc_d;
	logic          digit, is_op, accept;
	logic [3:0]    dval;
	op_t           op;
	logic [VW-1:0] acc10;

	assign accept = push && !q_full;

	// character classification
	always_comb begin
		digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		dval  = 4'(char_code - CH_ZERO);
		is_op = 1'b1;
		op    = OP_ADD;
		unique case (char_code)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			CH_PCT:   op = OP_MOD;
			default:  is_op = 1'b0;
		endcase
	end

	// acc * 10 + digit, wrapping
	assign acc10 = (acc_q << 3) + (acc_q << 1) + VW'(dval);

	// parser step and request build
	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		cmd.has_num = 1'b0;
		cmd.num     = acc_q;
		cmd.has_op  = 1'b0;
		cmd.op      = op;
		cmd.is_end  = last;
		unique case (phase_q)
			PH_WAIT_NUM: begin
				if (digit) begin
					acc_d   = VW'(dval);
					phase_d = PH_IN_NUM;
				end
			end
			PH_IN_NUM: begin
				if (digit) begin
					acc_d = acc10;
				end else begin
					cmd.has_num = 1'b1;
					acc_d       = '0;
					cmd.has_op  = is_op;
					phase_d     = is_op ? PH_WAIT_NUM : PH_WAIT_OP;
				end
			end
			PH_WAIT_OP: begin
				if (is_op) begin
					cmd.has_op = 1'b1;
					phase_d    = PH_WAIT_NUM;
				end
			end
			default: phase_d = PH_WAIT_NUM;
		endcase
		// an unfinished number is closed by the last character
		if (last && phase_d == PH_IN_NUM) begin
			cmd.has_num = 1'b1;
			cmd.num     = acc_d;
		end
	end

	assign cmd_valid = accept && (cmd.has_num || cmd.has_op || last);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_NUM;
			acc_q   <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q <= PH_WAIT_NUM;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
			end
		end
	end

endmodule

// ----- src/iee_cmdq.sv -----
// ----------------------------------------------------------------------------
// iee_cmdq
// Two-entry request queue between parser and evaluator.
// ----------------------------------------------------------------------------
module iee_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  iee_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output iee_pkg::cmd_t rd_data
);
	import iee_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ----- src/iee_div.sv -----
// ----------------------------------------------------------------------------
// iee_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [iee_pkg::VW-1:0] dividend,
	input  logic [iee_pkg::VW-1:0] divisor,
	output logic                   done,
	output logic [iee_pkg::VW-1:0] quotient,
	output logic [iee_pkg::VW-1:0] remainder
);
	import iee_pkg::*;

	logic [VW:0]     rem_q;
	logic [VW-1:0]   quo_q, dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic            run_q, done_q;
	logic [VW:0]     shifted, diff;

	assign shifted   = {rem_q[VW-1:0], quo_q[VW-1]};
	assign diff      = shifted - {1'b0, dsr_q};
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[VW-1:0];

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[VW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[VW-2:0], 1'b0};
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CW'(VW);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- src/iee_back.sv -----
// ----------------------------------------------------------------------------
// iee_back
// Evaluator: operand and operator stacks, precedence-driven reductions and
// the one-entry result register.
// ----------------------------------------------------------------------------
module iee_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  iee_pkg::cmd_t       cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  value,
	output logic [1:0]          error
);
	import iee_pkg::*;

	bstate_t       state_q, state_d;
	// operand stack, entry 0 is the top
	logic [VW-1:0] opd_q [3];
	logic [1:0]    opd_cnt_q;
	// operator stack, entry 0 is the top
	op_t           opr_q [2];
	logic [1:0]    opr_cnt_q;
	logic          pend_op_q, pend_end_q;
	op_t           cur_op_q;
	err_t          err_q;
	// divide bookkeeping
	logic          div_mod_q, neg_q;
	// result register
	logic          out_valid_q;
	logic signed [31:0] value_q;
	err_t          out_err_q;

	logic          hi_new, top_lo, enough, b_zero, red_quick;
	logic          scan_reduce, scan_pushop, scan_final, scan_done, div_start;
	logic [VW-1:0] a, b, quick_res, ma, mb, div_res;
	logic          na, nb, div_done;
	logic [VW-1:0] quo, rem;
	err_t          fin_err;
	logic signed [VW-1:0] top_s;

	assign a      = opd_q[1];
	assign b      = opd_q[0];
	assign na     = a[VW-1];
	assign nb     = b[VW-1];
	assign ma     = na ? (VW'(0) - a) : a;
	assign mb     = nb ? (VW'(0) - b) : b;
	assign b_zero = b == '0;
	assign enough = opd_cnt_q >= 2'd2;

	// precedence and operation decode
	always_comb begin
		hi_new    = 1'b0;
		top_lo    = 1'b0;
		red_quick = 1'b1;
		quick_res = a + b;
		unique case (cur_op_q)
			OP_MUL, OP_DIV, OP_MOD: hi_new = 1'b1;
			default:                hi_new = 1'b0;
		endcase
		unique case (opr_q[0])
			OP_ADD, OP_SUB: top_lo = 1'b1;
			default:        top_lo = 1'b0;
		endcase
		unique case (opr_q[0])
			OP_ADD:  quick_res = a + b;
			OP_SUB:  quick_res = a - b;
			OP_MUL:  quick_res = VW'(a * b);
			default: red_quick = 1'b0;
		endcase
	end

	// scan decisions
	always_comb begin
		scan_reduce = 1'b0;
		scan_pushop = 1'b0;
		scan_final  = 1'b0;
		scan_done   = 1'b0;
		if (state_q == B_SCAN) begin
			if (pend_op_q) begin
				if (opr_cnt_q != 2'd0 && !(hi_new && top_lo)) begin
					scan_reduce = 1'b1;
				end else begin
					scan_pushop = 1'b1;
				end
			end else if (pend_end_q) begin
				if (opr_cnt_q != 2'd0) begin
					scan_reduce = 1'b1;
				end else begin
					scan_final = !out_valid_q;
				end
			end else begin
				scan_done = 1'b1;
			end
		end
		div_start = scan_reduce && enough && !red_quick && !b_zero;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (cmd_valid) state_d = B_SCAN;
			B_SCAN: begin
				if (div_start) begin
					state_d = B_DIV;
				end else if (scan_done || scan_final) begin
					state_d = B_IDLE;
				end
			end
			B_DIV: if (div_done) state_d = B_SCAN;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		cmd_pop = (state_q == B_IDLE) && cmd_valid;
		div_res = div_mod_q ? (neg_q ? (VW'(0) - rem) : rem)
		                    : (neg_q ? (VW'(0) - quo) : quo);
		fin_err = err_q;
		if (err_q == ERR_NONE && opd_cnt_q == 2'd0) begin
			fin_err = ERR_MISSING;
		end
		top_s = opd_q[0];
	end

	iee_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (ma),
		.divisor   (mb),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// stack data
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_op_q <= cmd.op;
			if (cmd.has_num && opd_cnt_q != 2'd3) begin
				opd_q[0] <= cmd.num;
				opd_q[1] <= opd_q[0];
				opd_q[2] <= opd_q[1];
			end
		end
		if (scan_reduce) begin
			opr_q[0] <= opr_q[1];
			if (enough && (red_quick || b_zero)) begin
				opd_q[0] <= red_quick ? quick_res : '0;
				opd_q[1] <= opd_q[2];
			end
			div_mod_q <= opr_q[0] == OP_MOD;
			neg_q     <= (opr_q[0] == OP_MOD) ? na : (na ^ nb);
		end
		if (scan_pushop && opr_cnt_q != 2'd2) begin
			opr_q[0] <= cur_op_q;
			opr_q[1] <= opr_q[0];
		end
		if (state_q == B_DIV && div_done) begin
			opd_q[0] <= div_res;
			opd_q[1] <= opd_q[2];
		end
		if (scan_final) begin
			value_q <= (fin_err == ERR_NONE) ? 32'(top_s) : '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			opd_cnt_q   <= 2'd0;
			opr_cnt_q   <= 2'd0;
			pend_op_q   <= 1'b0;
			pend_end_q  <= 1'b0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
			out_err_q   <= ERR_NONE;
		end else begin
			state_q <= state_d;
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				pend_op_q  <= cmd.has_op;
				pend_end_q <= cmd.is_end;
				if (cmd.has_num && opd_cnt_q != 2'd3) begin
					opd_cnt_q <= opd_cnt_q + 2'd1;
				end
			end
			if (scan_reduce) begin
				opr_cnt_q <= opr_cnt_q - 2'd1;
				if (!enough) begin
					if (err_q == ERR_NONE) err_q <= ERR_MISSING;
				end else if (red_quick) begin
					opd_cnt_q <= opd_cnt_q - 2'd1;
				end else if (b_zero) begin
					opd_cnt_q <= opd_cnt_q - 2'd1;
					if (err_q == ERR_NONE) err_q <= ERR_DIV0;
				end
			end
			if (scan_pushop) begin
				pend_op_q <= 1'b0;
				if (opr_cnt_q != 2'd2) begin
					opr_cnt_q <= opr_cnt_q + 2'd1;
				end
			end
			if (state_q == B_DIV && div_done) begin
				opd_cnt_q <= opd_cnt_q - 2'd1;
			end
			// result out, evaluator back to its starting state
			if (scan_final) begin
				out_valid_q <= 1'b1;
				out_err_q   <= fin_err;
				opd_cnt_q   <= 2'd0;
				opr_cnt_q   <= 2'd0;
				pend_end_q  <= 1'b0;
				err_q       <= ERR_NONE;
			end
		end
	end

	assign empty = !out_valid_q;
	assign value = value_q;
	assign error = out_err_q;

endmodule

// ----- src/infix_expression_evaluator_top.sv -----
// Flow: the parser takes a character and queues a request; the evaluator pops it when idle, scans it with one
// step per operator push or reduction, and waits in its divide state for each divide or modulo.
// Throughput: one character per cycle while the two-entry request queue has room;
// the sustained rate is bounded by the evaluator, whose divides run through the iterative divider.
// Reset: arst_n clears parser, queue, stacks and result register; no result waits.
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top
// Infix integer expression evaluator: parser front, request queue and
// two-stack evaluator with an iterative divider.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_code,
	input  logic               last,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] value,
	output logic [1:0]         error
);
	import iee_pkg::*;

	logic q_full, wr_en, rd_en, rd_valid;
	cmd_t wr_cmd, rd_cmd;

	assign full = q_full;

	iee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.last      (last),
		.q_full    (q_full),
		.cmd_valid (wr_en),
		.cmd       (wr_cmd)
	);

	iee_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_cmd),
		.full     (q_full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_data  (rd_cmd)
	);

	iee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (rd_valid),
		.cmd       (rd_cmd),
		.cmd_pop   (rd_en),
		.empty     (empty),
		.pop       (pop),
		.value     (value),
		.error     (error)
	);

endmodule

// ----- src/iee_checker.sv -----
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks on the evaluator's result queue.
// ----------------------------------------------------------------------------
module iee_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] value,
	input logic [1:0]         error
);
	import iee_pkg::*;

	// error code stays within the defined codes
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (error == ERR_NONE || error == ERR_DIV0 || error == ERR_MISSING))
		else $error("undefined error code");

	// a failed expression reports zero
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error != ERR_NONE) |-> value == 32'sd0)
		else $error("nonzero value with error");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(error)))
		else $error("waiting result changed");

	// a taken result leaves the queue empty
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result repeated");

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.value  (value),
	.error  (error)
);

// ----- test/infix_expression_evaluator_top_test.sv -----
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top_test
// Streams expression characters into the evaluator with random push and pop
// idling, predicts each result with a two-stack model and checks value and
// error of every result in order.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import iee_pkg::*;

	// one predicted result
	typedef struct {
		logic signed [31:0] value;
		err_t               error;
	} outcome_t;

	// scoreboard: evaluation model and queue of predicted results
	class expr_scoreboard;
		logic [31:0] operands [3];
		int          n_operands;
		op_t         operators [2];
		int          n_operators;
		logic [31:0] acc;
		phase_t      phase;
		err_t        err;
		outcome_t    pending [$];
		int          errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			n_operands = 0;
			n_operators = 0;
			acc = '0;
			phase = PH_WAIT_NUM;
			err = ERR_NONE;
		endfunction

		function void flag(err_t e);
			if (err == ERR_NONE)
				err = e;
		endfunction

		function void push_num(logic [31:0] v);
			if (n_operands < 3) begin
				operands[n_operands] = v;
				n_operands++;
			end
		endfunction

		function logic [31:0] apply(logic [31:0] a, op_t op, logic [31:0] b);
			logic [31:0] ma, mb, r;
			case (op)
				OP_ADD: return a + b;
				OP_SUB: return a - b;
				OP_MUL: return a * b;
				default: begin
					if (b == 0) begin
						flag(ERR_DIV0);
						return '0;
					end
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					if (op == OP_DIV) begin
						r = ma / mb;
						return (a[31] != b[31]) ? -r : r;
					end
					r = ma % mb;
					return a[31] ? -r : r;
				end
			endcase
		endfunction

		function void reduce();
			op_t op;
			logic [31:0] a, b;
			if (n_operators == 0)
				return;
			n_operators--;
			op = operators[n_operators];
			if (n_operands < 2) begin
				flag(ERR_MISSING);
				return;
			end
			b = operands[n_operands - 1];
			a = operands[n_operands - 2];
			n_operands -= 2;
			push_num(apply(a, op, b));
		endfunction

		function void take_operator(op_t op);
			while (n_operators > 0) begin
				if (op >= OP_MUL && operators[n_operators - 1] < OP_MUL)
					break;
				reduce();
			end
			if (n_operators < 2) begin
				operators[n_operators] = op;
				n_operators++;
			end
			phase = PH_WAIT_NUM;
		endfunction

		// note an accepted character request
		function void note_char(logic [7:0] c, logic fin);
			logic is_digit, is_op;
			op_t op;
			outcome_t o;
			is_digit = (c >= CH_ZERO && c <= CH_NINE);
			is_op = 1'b1;
			op = OP_ADD;
			case (c)
				CH_PLUS:  op = OP_ADD;
				CH_MINUS: op = OP_SUB;
				CH_STAR:  op = OP_MUL;
				CH_SLASH: op = OP_DIV;
				CH_PCT:   op = OP_MOD;
				default:  is_op = 1'b0;
			endcase
			case (phase)
				PH_WAIT_NUM: if (is_digit) begin
					acc = 32'(c - CH_ZERO);
					phase = PH_IN_NUM;
				end
				PH_IN_NUM: if (is_digit) begin
					acc = acc * 10 + 32'(c - CH_ZERO);
				end else begin
					push_num(acc);
					acc = '0;
					if (is_op)
						take_operator(op);
					else
						phase = PH_WAIT_OP;
				end
				default: if (is_op)
					take_operator(op);
			endcase
			if (!fin)
				return;
			if (phase == PH_IN_NUM)
				push_num(acc);
			while (n_operators > 0)
				reduce();
			if (n_operands == 0)
				flag(ERR_MISSING);
			o.error = err;
			o.value = (err == ERR_NONE) ? operands[n_operands - 1] : '0;
			pending.push_back(o);
			clear();
		endfunction

		// compare one accepted result with the oldest prediction
		function void check(logic signed [31:0] v, logic [1:0] e);
			outcome_t o;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%0d error=%0d", v, e));
				return;
			end
			o = pending.pop_front();
			if (v !== o.value)
				report_mismatch($sformatf("value %0d, predicted %0d", v, o.value));
			if (e !== o.error)
				report_mismatch($sformatf("error %0d, predicted %0d", e, o.error));
		endfunction

		function void report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         char_code;
	logic               last;
	logic               empty;
	logic               pop;
	logic signed [31:0] value;
	logic [1:0]         error;

	expr_scoreboard sb;
	int push_idle_pct;
	int pop_stall_pct;

	infix_expression_evaluator_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.char_code(char_code), .last(last), .empty(empty), .pop(pop),
		.value(value), .error(error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("infix_expression_evaluator_top regression: fail");
		$finish;
	end

	// send one character request, waiting for acceptance
	task automatic send_char(logic [7:0] c, logic fin);
		while ($urandom_range(99) < push_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		last <= fin;
		do @(posedge clk); while (full);
		sb.note_char(c, fin);
		@(negedge clk);
	endtask

	task automatic send_expr(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_op();
		case ($urandom_range(4))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			default: return CH_PCT;
		endcase
	endfunction

	function automatic string rand_number();
		string s;
		int n;
		s = "";
		n = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			s = {s, string'(8'(CH_ZERO + (($urandom_range(5) == 0) ? 0 : $urandom_range(9))))};
		return s;
	endfunction

	// mostly well-formed expressions, some noise and broken ones
	function automatic string rand_expr();
		string s;
		int terms;
		s = rand_number();
		terms = $urandom_range(0, 5);
		for (int i = 0; i < terms; i++) begin
			if ($urandom_range(9) == 0)
				s = {s, " "};
			s = {s, string'(rand_op())};
			if ($urandom_range(14) == 0)
				s = {s, string'(rand_op())};
			if ($urandom_range(9) == 0)
				s = {s, string'(8'($urandom_range(255)))};
			s = {s, rand_number()};
		end
		if ($urandom_range(19) == 0)
			s = {s, string'(rand_op())};
		return s;
	endfunction

	// stop sending and wait for every predicted result
	task automatic wait_drain();
		push <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// result side: pop with random stalls, check on each accepted result
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= pop_stall_pct);
			@(posedge clk);
			if (pop && !empty)
				sb.check(value, error);
		end
	end

	initial begin
		string s;
		sb = new();
		push = 1'b0;
		char_code = '0;
		last = 1'b0;
		push_idle_pct = 0;
		pop_stall_pct = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed expressions covering operators and corner cases
		send_expr("1+2*3");
		send_expr("7-3-2");
		send_expr("4294967295*4294967295");
		send_expr("2147483648/4294967295");
		send_expr("2147483648%4294967295");
		send_expr("0-7/2");
		send_expr("0-7%2");
		send_expr("5/0");
		send_expr("5%0+1/0");
		send_expr("+-");
		send_expr("x");
		send_expr("12 34+1");
		send_expr("3*+4");
		send_expr("99999999999");
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		send_expr("8-2*3%4/1+6");
		wait_drain();

		// random phases with varying idling
		for (int p = 0; p < 4; p++) begin
			push_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 36 : 62) : 0;
			pop_stall_pct = (p == 2) ? 62 : ((p == 3) ? 36 : 0);
			for (int k = 0; k < 500; ) begin
				s = rand_expr();
				send_expr(s);
				k += s.len();
			end
			wait_drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("infix_expression_evaluator_top regression: pass");
		else
			$display("infix_expression_evaluator_top regression: fail");
		$finish;
	end

endmodule

// ----- infix_expression_evaluator_top.f -----
src/iee_pkg.sv
src/iee_front.sv
src/iee_cmdq.sv
src/iee_div.sv
src/iee_back.sv
src/infix_expression_evaluator_top.sv
src/iee_checker.sv
test/infix_expression_evaluator_top_test.sv
